### hw/rtl/dcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcr_pkg;

  localparam int NUM_LANES    = 8;
  localparam int VAL_W        = 8;
  localparam int NV_W         = 4;
  localparam int THR_W        = 8;
  localparam int CFG_ADDR_W   = 1;
  localparam int CFG_DATA_W   = 8;
  localparam int DATA_W       = NUM_LANES * VAL_W;

  localparam int MAX_VARS_DEF = 8;
  localparam int CAPACITY_DEF = 256;

  localparam logic [NV_W-1:0]  NUM_VARS_RST  = NV_W'(8);
  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(8);

  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_VARS  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 1'b1;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // control broadcast from the merge stage to every lane
  typedef struct packed {
    logic take;    // item accepted this cycle
    logic flush;   // item is a flush
    logic add_ok;  // add that is not dropped for a full count
    logic fire;    // held tuple goes out, marks clear before the update
  } lane_ctl_t;

  // per-lane findings for the merge stage
  typedef struct packed {
    logic fire_req;  // pending, active and moved past the threshold
    logic pend_hit;  // pending and active
  } lane_stat_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              status;
    logic              sent;
  } result_t;

  function automatic logic [VAL_W-1:0] abs_diff(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/dcr_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module dcr_lane #(
  parameter int LANE_IDX = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [dcr_pkg::NV_W-1:0]    n_act,
  input  wire logic [dcr_pkg::THR_W-1:0]   thr,
  input  wire logic [dcr_pkg::VAL_W-1:0]   val,
  input  wire dcr_pkg::lane_ctl_t          ctl,
  output dcr_pkg::lane_stat_t              stat,
  output logic      [dcr_pkg::VAL_W-1:0]   emit_val
);

  logic [dcr_pkg::VAL_W-1:0] held_r, held_nxt;
  logic                      pend_r, pend_nxt;
  logic                      active;
  logic                      moves;

  assign active = dcr_pkg::NV_W'(LANE_IDX) < n_act;
  assign moves  = dcr_pkg::abs_diff(val, held_r) > thr;

  assign stat.fire_req = active & pend_r & moves;
  assign stat.pend_hit = active & pend_r;
  assign emit_val      = active ? held_r : '0;

  always_comb begin
    held_nxt = held_r;
    pend_nxt = pend_r;
    if (ctl.take) begin
      if (ctl.flush) begin
        pend_nxt = 1'b0;
      end else if (ctl.add_ok) begin
        if (ctl.fire) begin
          pend_nxt = 1'b0;
        end
        // a fire clears the mark first, so a moving lane may take the value
        if (active && moves && (!pend_r || ctl.fire)) begin
          held_nxt = val;
          pend_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      pend_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dcr_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module dcr_merge #(
  parameter int CAPACITY = dcr_pkg::CAPACITY_DEF
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst_n,
  input  wire logic                                           take,
  input  wire logic                                           cmd,
  input  wire dcr_pkg::lane_stat_t [dcr_pkg::NUM_LANES-1:0]   stat,
  input  wire logic [dcr_pkg::NUM_LANES-1:0][dcr_pkg::VAL_W-1:0] emit_val,
  output dcr_pkg::lane_ctl_t                                  ctl,
  output dcr_pkg::result_t                                    res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        full;
  logic                        flush;
  logic                        fire_add, fire_flush, fire;
  logic [dcr_pkg::DATA_W-1:0]  data_mux;

  assign flush = (cmd == dcr_pkg::CMD_FLUSH);
  assign full  = cnt_r >= CNT_W'(CAPACITY);

  always_comb begin
    fire_add   = 1'b0;
    fire_flush = 1'b0;
    for (int j = 0; j < dcr_pkg::NUM_LANES; j++) begin
      fire_add   = fire_add | stat[j].fire_req;
      fire_flush = fire_flush | stat[j].pend_hit;
    end
  end

  assign fire = flush ? fire_flush : (!full & fire_add);

  assign ctl.take   = take;
  assign ctl.flush  = flush;
  assign ctl.add_ok = !flush && !full;
  assign ctl.fire   = fire;

  always_comb begin
    for (int j = 0; j < dcr_pkg::NUM_LANES; j++) begin
      data_mux[j*dcr_pkg::VAL_W +: dcr_pkg::VAL_W] = fire ? emit_val[j] : '0;
    end
  end

  assign res.sent   = fire;
  assign res.status = !flush && full;
  assign res.data   = data_mux;

  always_comb begin
    cnt_nxt = cnt_r;
    if (take) begin
      if (flush) begin
        cnt_nxt = '0;
      end else if (!full) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_sent_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> !(res.sent && res.status))
    else $error("dropped add reported a sent tuple");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("sample count beyond capacity");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && flush) |=> (cnt_r == '0))
    else $error("flush did not reset the sample count");

  a_drop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res.status) |=> (cnt_r == $past(cnt_r)))
    else $error("dropped add changed the sample count");

endmodule

`default_nettype wire

### hw/rtl/dcr_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module dcr_out_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire dcr_pkg::result_t  push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output dcr_pkg::result_t       pop_data
);

  logic             main_v_r, skid_v_r;
  dcr_pkg::result_t main_d_r, skid_d_r;
  logic             push, pop;

  assign push_ready = !skid_v_r;
  assign push       = push_valid && push_ready;
  assign pop        = main_v_r && pop_ready;
  assign pop_valid  = main_v_r;
  assign pop_data   = main_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_v_r) begin
          main_d_r <= skid_d_r;
          skid_v_r <= 1'b0;
        end else if (push) begin
          main_d_r <= push_data;
        end else begin
          main_v_r <= 1'b0;
        end
      end else if (push) begin
        if (!main_v_r) begin
          main_d_r <= push_data;
          main_v_r <= 1'b1;
        end else begin
          skid_d_r <= push_data;
          skid_v_r <= 1'b1;
        end
      end
    end
  end

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid holds an item with the output register empty");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (main_v_r && !pop_ready && !skid_v_r && push_valid) |=> skid_v_r)
    else $error("item lost while output stalled");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && pop_ready) |=> !skid_v_r)
    else $error("skid item not moved on pop");

endmodule

`default_nettype wire

### hw/rtl/deadband_change_reporter.sv
// A result is formed as its item is accepted, then registered in the output buffer.
// Throughput: one item per cycle while the output buffer has room (in_tready high); the
// lane compares, the fire OR and the held-value update all settle in the cycle of
// acceptance, and a two-entry output buffer takes the next item while a result waits.
// Reset (rst_n low at a clock edge): held values and pending marks zero, sample count
// zero, num_vars and threshold 8, output buffer empty.
`timescale 1ns / 1ps
`default_nettype none

module deadband_change_reporter #(
  parameter int MAX_VARS = dcr_pkg::MAX_VARS_DEF,
  parameter int CAPACITY = dcr_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // value_0 .. value_7, 8 bits each, value_0 lowest
  input  wire logic [dcr_pkg::DATA_W-1:0]        in_tdata,
  // cmd
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_0 .. out_7, 8 bits each, out_0 lowest
  output logic      [dcr_pkg::DATA_W-1:0]        out_tdata,
  // bit 0 sent, bit 1 status
  output logic      [1:0]                        out_tuser,
  input  wire logic                              cfg_we,
  input  wire logic [dcr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [dcr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [dcr_pkg::NV_W-1:0]  num_vars_r;
  logic [dcr_pkg::THR_W-1:0] thr_r;
  logic [dcr_pkg::NV_W-1:0]  n_act;
  logic                      take;

  dcr_pkg::lane_ctl_t                              ctl;
  dcr_pkg::lane_stat_t [dcr_pkg::NUM_LANES-1:0]    stat;
  logic [dcr_pkg::NUM_LANES-1:0][dcr_pkg::VAL_W-1:0] emit_val;
  dcr_pkg::result_t                                res, out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r <= dcr_pkg::NUM_VARS_RST;
      thr_r      <= dcr_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      if (cfg_addr == dcr_pkg::CFG_NUM_VARS) begin
        num_vars_r <= cfg_wdata[dcr_pkg::NV_W-1:0];
      end else if (cfg_addr == dcr_pkg::CFG_THRESHOLD) begin
        thr_r <= cfg_wdata[dcr_pkg::THR_W-1:0];
      end
    end
  end

  assign n_act = (num_vars_r > dcr_pkg::NV_W'(MAX_VARS)) ? dcr_pkg::NV_W'(MAX_VARS)
                                                         : num_vars_r;
  assign take  = in_tvalid && in_tready;

  for (genvar j = 0; j < dcr_pkg::NUM_LANES; j++) begin : g_lane
    if (j < MAX_VARS) begin : g_on
      dcr_lane #(
        .LANE_IDX(j)
      ) u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .n_act    (n_act),
        .thr      (thr_r),
        .val      (in_tdata[j*dcr_pkg::VAL_W +: dcr_pkg::VAL_W]),
        .ctl      (ctl),
        .stat     (stat[j]),
        .emit_val (emit_val[j])
      );
    end else begin : g_off
      assign stat[j]     = '0;
      assign emit_val[j] = '0;
    end
  end

  dcr_merge #(
    .CAPACITY(CAPACITY)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .cmd      (in_tuser),
    .stat     (stat),
    .emit_val (emit_val),
    .ctl      (ctl),
    .res      (res)
  );

  dcr_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_data  (res),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_data   (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tuser = {out_res.status, out_res.sent};

endmodule

`default_nettype wire
